// File: src/per_key_grant_storm_detector_top_defines.svh
// Assertion macros for the grant storm detector
`ifndef PER_KEY_GRANT_STORM_DETECTOR_TOP_DEFINES_SVH
`define PER_KEY_GRANT_STORM_DETECTOR_TOP_DEFINES_SVH
`define PKG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PKG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/pkgsd_pkg.sv
// Package with constants and types of the grant storm detector
`default_nettype none
package pkgsd_pkg;
   localparam int TableEntries = 64;
   localparam int RightCount = 64;
   localparam int IdxW = $clog2(TableEntries);
   localparam int KeyW = 17;
   localparam int TimeW = 32;
   localparam int RightW = 6;
   localparam int CntW = 7;
   localparam int WinW = 16;
   localparam int MaskW = 64;
   localparam int SlotW = 6;
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_STORM_LIMIT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_SENS_MASK = 2'd2;
   localparam logic [CntW-1:0] STORM_LIMIT_RST = 7'd3;
   localparam logic [WinW-1:0] WINDOW_RST = 16'd30;
   localparam logic [MaskW-1:0] SENS_MASK_RST = 64'd31;

   typedef struct packed {
      logic [KeyW-1:0] proc_id;
      logic [TimeW-1:0] now_seconds;
      logic [RightW-1:0] right_id;
      logic granted;
      logic is_tcc;
      logic platform_binary;
      logic has_team;
   } req_type;

   typedef struct packed {
      logic [CntW-1:0] distinct_count;
      logic storm_alert;
      logic sensitive_alert;
      logic [SlotW-1:0] entry_slot;
   } rsp_type;

   // token passed down the cell chain
   typedef struct packed {
      logic hit;
      logic [IdxW-1:0] hit_idx;
      logic have_free;
      logic [IdxW-1:0] free_idx;
      logic have_old;
      logic [IdxW-1:0] old_idx;
      logic [TimeW-1:0] old_start;
   } scan_type;

   typedef struct packed {
      logic valid;
      logic [KeyW-1:0] key;
      logic [TimeW-1:0] start;
   } tag_type;
endpackage
`default_nettype wire

// File: src/pkgsd_stream_if.sv
// Valid/ready channel interface
`default_nettype none
interface pkgsd_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/per_key_grant_storm_detector_top.sv
// Top level of the per-key grant storm detector
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | proc_id now_seconds right_id flags
//  rsp     | out | rsp_valid/ready    | distinct_count alerts entry_slot
//  csr     | in  | csr_write_enable   | csr_index csr_write_data
//
// A granted TCC transaction first lets the scan token walk the tag chain,
// one register per cell, then does a RAM read and a read-modify-write. Ignored
// transactions go straight to the done state. One transaction at a time; the
// next is taken once the result has left the output register.
// Reset clears all tag valid bits at once; no clearing pass.
`default_nettype none
`include "per_key_grant_storm_detector_top_defines.svh"
module per_key_grant_storm_detector_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [pkgsd_pkg::KeyW-1:0] req_proc_id,
   input wire logic [pkgsd_pkg::TimeW-1:0] req_now_seconds,
   input wire logic [pkgsd_pkg::RightW-1:0] req_right_id,
   input wire logic req_granted,
   input wire logic req_is_tcc,
   input wire logic req_platform_binary,
   input wire logic req_has_team,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [pkgsd_pkg::CntW-1:0] rsp_distinct_count,
   output logic rsp_storm_alert,
   output logic rsp_sensitive_alert,
   output logic [pkgsd_pkg::SlotW-1:0] rsp_entry_slot,
   input wire logic csr_write_enable,
   input wire logic [pkgsd_pkg::CsrIdxW-1:0] csr_index,
   input wire logic [pkgsd_pkg::MaskW-1:0] csr_write_data
);
   import pkgsd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_READ = 5'b00100,
      ST_UPD  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   localparam int CntBits = $clog2(TableEntries + 1);

   pkgsd_stream_if #(.payload_type(req_type)) req_ch ();
   pkgsd_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.payload = '{req_proc_id, req_now_seconds, req_right_id, req_granted,
                             req_is_tcc, req_platform_binary, req_has_team};
   assign req_ready = req_ch.ready;
   assign rsp_valid = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign rsp_distinct_count = rsp_ch.payload.distinct_count;
   assign rsp_storm_alert = rsp_ch.payload.storm_alert;
   assign rsp_sensitive_alert = rsp_ch.payload.sensitive_alert;
   assign rsp_entry_slot = rsp_ch.payload.entry_slot;

   state_type state_ff, state_in;
   req_type req_ff;
   logic [CntW-1:0] limit_ff;
   logic [WinW-1:0] window_ff;
   logic [MaskW-1:0] mask_ff;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] slot_ff;
   logic hit_ff;
   rsp_type out_ff;
   logic out_valid_ff;

   scan_type chain [TableEntries+1];
   tag_type tag_rd;
   logic [IdxW-1:0] ram_addr;
   logic ram_we;
   logic [CntW+MaskW-1:0] ram_wdata, ram_rdata;
   tag_type wr_tag;
   logic shift;

   assign chain[0] = '0;
   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_IDLE);

   for (genvar g = 0; g < TableEntries; g++) begin : g_cell
      pkgsd_cell u_cell (
         .clock(clock), .reset(reset),
         .my_idx(IdxW'(g)),
         .key(req_ff.proc_id),
         .wr_en(ram_we && slot_ff == IdxW'(g)),
         .wr_tag(wr_tag),
         .shift(shift),
         .scan_i(chain[g]),
         .scan_o(chain[g+1])
      );
   end

   // count, bitmap and tag of the chosen slot
   logic new_win;
   logic [TimeW-1:0] age;
   logic expired;
   logic [MaskW-1:0] bitm;
   logic [MaskW-1:0] seen;
   logic [CntW-1:0] total, total_new;
   logic [MaskW-1:0] seen_new;

   assign ram_addr = slot_ff;
   pkgsd_ram #(.Width(CntW + MaskW), .Depth(TableEntries)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );
   pkgsd_ram #(.Width(KeyW + TimeW + 1), .Depth(TableEntries)) u_tag_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(wr_tag), .rd_data(tag_rd)
   );

   always_comb begin
      bitm = MaskW'(1) << req_ff.right_id;
      age = req_ff.now_seconds - tag_rd.start;
      expired = (req_ff.now_seconds >= tag_rd.start) && (age > TimeW'(window_ff));
      new_win = !hit_ff || expired;
      seen = new_win ? '0 : ram_rdata[MaskW-1:0];
      total = new_win ? '0 : ram_rdata[CntW+MaskW-1:MaskW];
      seen_new = seen | bitm;
      total_new = ((seen & bitm) == '0) ? total + CntW'(1) : total;
      wr_tag.valid = 1'b1;
      wr_tag.key = req_ff.proc_id;
      wr_tag.start = new_win ? req_ff.now_seconds : tag_rd.start;
      ram_wdata = {total_new, seen_new};
      ram_we = (state_ff == ST_UPD);
   end

   logic act;
   assign act = req_ch.payload.granted && req_ch.payload.is_tcc &&
                (32'(req_ch.payload.right_id) < RightCount);
   assign req_ch.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               state_in = act ? ST_SCAN : ST_DONE;
               cnt_in = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CntBits'(1);
            if (cnt_ff == CntBits'(TableEntries)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_UPD;
         ST_UPD: state_in = ST_IDLE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         limit_ff <= STORM_LIMIT_RST;
         window_ff <= WINDOW_RST;
         mask_ff <= SENS_MASK_RST;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (csr_write_enable) begin
            priority if (csr_index == CSR_STORM_LIMIT) begin
               limit_ff <= csr_write_data[CntW-1:0];
            end else if (csr_index == CSR_WINDOW) begin
               window_ff <= csr_write_data[WinW-1:0];
            end else if (csr_index == CSR_SENS_MASK) begin
               mask_ff <= csr_write_data;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end else if (state_ff == ST_UPD || state_ff == ST_DONE) begin
            out_valid_ff <= 1'b1;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         req_ff <= req_ch.payload;
      end
      if (state_ff == ST_SCAN && cnt_ff == CntBits'(TableEntries)) begin
         hit_ff <= chain[TableEntries].hit;
         slot_ff <= chain[TableEntries].hit ? chain[TableEntries].hit_idx :
                    chain[TableEntries].have_free ? chain[TableEntries].free_idx :
                    chain[TableEntries].old_idx;
      end
      if (state_ff == ST_DONE) begin
         out_ff <= '0;
      end else if (state_ff == ST_UPD) begin
         out_ff.distinct_count <= total_new;
         out_ff.storm_alert <= total_new > limit_ff;
         out_ff.sensitive_alert <= ((mask_ff & bitm) != '0) &&
                                   !req_ff.platform_binary && !req_ff.has_team;
         out_ff.entry_slot <= SlotW'(slot_ff);
      end
   end

   `PKG_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `PKG_ASSERT_NEXT(a_upd_out, clock, reset, state_ff == ST_UPD, rsp_valid, "no result after update")
   `PKG_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_valid, !req_ready, "accept while result pending")
endmodule
`default_nettype wire

// File: src/pkgsd_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module pkgsd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wr_data,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: src/pkgsd_cell.sv
// One tag cell: holds one entry's tag and merges it into the passing scan token
`default_nettype none
module pkgsd_cell (
   input wire logic clock,
   input wire logic reset,
   input wire logic [pkgsd_pkg::IdxW-1:0] my_idx,
   input wire logic [pkgsd_pkg::KeyW-1:0] key,
   input wire logic wr_en,
   input wire pkgsd_pkg::tag_type wr_tag,
   input wire logic shift,
   input wire pkgsd_pkg::scan_type scan_i,
   output pkgsd_pkg::scan_type scan_o
);
   import pkgsd_pkg::*;

   tag_type tag_ff;
   scan_type scan_ff, scan_in;

   always_comb begin
      scan_in = scan_i;
      if (tag_ff.valid) begin
         if (tag_ff.key == key && !scan_i.hit) begin
            scan_in.hit = 1'b1;
            scan_in.hit_idx = my_idx;
         end
         if (!scan_i.have_old || tag_ff.start < scan_i.old_start) begin
            scan_in.have_old = 1'b1;
            scan_in.old_idx = my_idx;
            scan_in.old_start = tag_ff.start;
         end
      end else if (!scan_i.have_free) begin
         scan_in.have_free = 1'b1;
         scan_in.free_idx = my_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (wr_en) begin
         tag_ff.valid <= wr_tag.valid;
      end
      if (wr_en) begin
         tag_ff.key <= wr_tag.key;
         tag_ff.start <= wr_tag.start;
      end
      if (shift) begin
         scan_ff <= scan_in;
      end
   end

   assign scan_o = scan_ff;
endmodule
`default_nettype wire
